FILE: sv/sec_pkg.sv
// shared types and constants of the set equality checker
package sec_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ACT_APPEND_A = 2'd0,
    ACT_APPEND_B = 2'd1,
    ACT_COMPARE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FIRST,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start_cmp;
    logic swap;
    logic j_clr;
    logic j_inc;
    logic i_inc;
    logic finish;
    logic same;
  } cmd_t;

  typedef struct packed {
    logic src_end;
    logic dst_empty;
    logic dst_end;
    logic hit;
  } sts_t;

endpackage

FILE: sv/sec_ctrl.sv
// controller of the set equality checker: load decode and compare sequencing
module sec_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    action_i,
  input  sec_pkg::sts_t sts_i,
  output sec_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import sec_pkg::*;

  state_e  state_q, state_d;
  action_e act;
  logic    dir_q, dir_d;
  logic    take;

  assign act    = action_e'(action_i);
  assign take   = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dir_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    case (state_q)
      ST_IDLE: begin
        if (take && act == ACT_COMPARE) begin
          state_d = ST_FETCH;
          dir_d   = 1'b0;
        end
      end
      ST_FETCH: begin
        if (sts_i.src_end) begin
          if (!dir_q) begin
            dir_d = 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (sts_i.dst_empty) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_FETCH;
        end else if (sts_i.dst_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          case (act)
            ACT_APPEND_A: cmd_o.load_a    = 1'b1;
            ACT_APPEND_B: cmd_o.load_b    = 1'b1;
            ACT_COMPARE:  cmd_o.start_cmp = 1'b1;
            default:      cmd_o           = '0;
          endcase
        end
      end
      ST_FETCH: begin
        if (sts_i.src_end) begin
          if (!dir_q) begin
            cmd_o.swap = 1'b1;
          end else begin
            cmd_o.finish = 1'b1;
            cmd_o.same   = 1'b1;
          end
        end else begin
          cmd_o.j_clr = 1'b1;
        end
      end
      ST_FIRST: begin
        if (sts_i.dst_empty) begin
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.i_inc = 1'b1;
        end else if (sts_i.dst_end) begin
          cmd_o.finish = 1'b1;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  a_cmp_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FETCH && $past(state_q == ST_IDLE))
      |-> $past(start_i && action_i == ACT_COMPARE))
    else $error("compare entered without a compare word");

  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (state_q != ST_IDLE) && !cmd_o.load_a && !cmd_o.load_b)
    else $error("finish issued while idle");

endmodule

FILE: sv/sec_dpath.sv
// datapath of the set equality checker: list memories, counters and result register
module sec_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [sec_pkg::DATA_W-1:0] value_i,
  input  sec_pkg::cmd_t                cmd_i,
  output sec_pkg::sts_t                sts_o,
  output logic                         done_o,
  output logic                         same_o,
  output logic                         overflow_o
);
  import sec_pkg::*;

  logic [DATA_W-1:0] mem_a [CAPACITY];
  logic [DATA_W-1:0] mem_b [CAPACITY];
  logic [DATA_W-1:0] rd_a_q, rd_b_q;
  logic [CNT_W-1:0]  count_a_q, count_b_q;
  logic [CNT_W-1:0]  i_q, j_q;
  logic [CNT_W-1:0]  ns, nd;
  logic [ADDR_W-1:0] addr_a, addr_b;
  logic              dropped_q, dir_q;
  logic              full_a, full_b;
  logic              done_q, same_q, overflow_q;

  assign full_a = (count_a_q >= CNT_W'(CAPACITY));
  assign full_b = (count_b_q >= CNT_W'(CAPACITY));
  assign ns     = dir_q ? count_b_q : count_a_q;
  assign nd     = dir_q ? count_a_q : count_b_q;
  assign addr_a = dir_q ? j_q[ADDR_W-1:0] : i_q[ADDR_W-1:0];
  assign addr_b = dir_q ? i_q[ADDR_W-1:0] : j_q[ADDR_W-1:0];

  assign sts_o.src_end   = (i_q >= ns);
  assign sts_o.dst_empty = (nd == '0);
  assign sts_o.dst_end   = (j_q >= nd);
  assign sts_o.hit       = (rd_a_q == rd_b_q);

  // list memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && !full_a) begin
      mem_a[count_a_q[ADDR_W-1:0]] <= value_i;
    end
    if (cmd_i.load_b && !full_b) begin
      mem_b[count_b_q[ADDR_W-1:0]] <= value_i;
    end
    rd_a_q <= mem_a[addr_a];
    rd_b_q <= mem_b[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_a_q  <= '0;
      count_b_q  <= '0;
      dropped_q  <= 1'b0;
      dir_q      <= 1'b0;
      i_q        <= '0;
      j_q        <= '0;
      done_q     <= 1'b0;
      same_q     <= 1'b0;
      overflow_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.finish) begin
        same_q     <= cmd_i.same;
        overflow_q <= dropped_q;
        count_a_q  <= '0;
        count_b_q  <= '0;
        dropped_q  <= 1'b0;
      end
      if (cmd_i.load_a) begin
        if (full_a) begin
          dropped_q <= 1'b1;
        end else begin
          count_a_q <= count_a_q + CNT_W'(1);
        end
      end
      if (cmd_i.load_b) begin
        if (full_b) begin
          dropped_q <= 1'b1;
        end else begin
          count_b_q <= count_b_q + CNT_W'(1);
        end
      end
      if (cmd_i.start_cmp) begin
        dir_q <= 1'b0;
        i_q   <= '0;
      end else if (cmd_i.swap) begin
        dir_q <= 1'b1;
        i_q   <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= i_q + CNT_W'(1);
      end
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + CNT_W'(1);
      end
    end
  end

  assign done_o     = done_q;
  assign same_o     = same_q;
  assign overflow_o = overflow_q;

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result word repeated");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_a_q <= CNT_W'(CAPACITY)) && (count_b_q <= CNT_W'(CAPACITY)))
    else $error("list count beyond capacity");

  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (count_a_q == '0) && (count_b_q == '0) && !dropped_q)
    else $error("lists not cleared after compare");

endmodule

FILE: sv/set_equality_checker.sv
// top level of the set equality checker
//
//   channel  | handshake                    | fields
//   ---------+------------------------------+------------------------
//   input    | start_i high, busy_o low     | action_i, value_i
//   result   | done_o high for one cycle    | same_o, overflow_o
//
// append words are taken back to back while busy_o is low, and never raise busy_o
// a compare holds busy_o while it scans, for each entry of both lists, the entries of the
// other list up to the first match; a value with no match ends it early
// after reset both lists are empty and the overflow mark is clear; no clearing pass
// the result cannot be stalled; done_o is high for one cycle from the edge where busy_o falls
module set_equality_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [1:0]                         action_i,
  input  logic signed [sec_pkg::DATA_W-1:0]  value_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic                               same_o,
  output logic                               overflow_o
);
  import sec_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sec_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  sec_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .same_o     (same_o),
    .overflow_o (overflow_o)
  );

endmodule

FILE: test/testbench.sv
// testbench of the set equality checker: directed and random list words checked against a predictor
`timescale 1ns / 100ps

module testbench;
  import sec_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WORD_TARGET  = 950;
  localparam int MIN_COMPARES = 60;
  localparam int TAIL_CYCLES  = 40;
  localparam int CYCLE_LIMIT  = 4_000_000;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic same;
    logic overflow;
  } verdict_t;

  typedef enum int {
    MIX_EQUAL,
    MIX_ALTERED,
    MIX_UNRELATED
  } mix_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic [1:0]               action_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     busy_o;
  logic                     done_o;
  logic                     same_o;
  logic                     overflow_o;

  word_t    set_a [CAPACITY];
  word_t    set_b [CAPACITY];
  int       fill_a;
  int       fill_b;
  bit       lost_word;
  verdict_t pending_verdicts[$];

  int words_sent;
  int compares_sent;
  int fail_count;
  int cycle_count;
  bit burst_mode;

  set_equality_checker dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .action_i   (action_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .same_o     (same_o),
    .overflow_o (overflow_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic bit word_in_list(bit in_a, word_t w);
    int n;
    int k;
    n = in_a ? fill_a : fill_b;
    for (k = 0; k < n; k++) begin
      if ((in_a ? set_a[k] : set_b[k]) == w) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit list_covered(bit src_a);
    int n;
    int k;
    n = src_a ? fill_a : fill_b;
    for (k = 0; k < n; k++) begin
      if (!word_in_list(!src_a, src_a ? set_a[k] : set_b[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void track_word(logic [1:0] act, word_t val);
    verdict_t v;
    case (act)
      ACT_APPEND_A: begin
        if (fill_a < CAPACITY) begin
          set_a[fill_a] = val;
          fill_a++;
        end else begin
          lost_word = 1'b1;
        end
      end
      ACT_APPEND_B: begin
        if (fill_b < CAPACITY) begin
          set_b[fill_b] = val;
          fill_b++;
        end else begin
          lost_word = 1'b1;
        end
      end
      ACT_COMPARE: begin
        v.same     = list_covered(1'b1) && list_covered(1'b0);
        v.overflow = lost_word;
        pending_verdicts.insert(pending_verdicts.size(), v);
        fill_a    = 0;
        fill_b    = 0;
        lost_word = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      4:       return word_t'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic [1:0] act, input word_t val);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk_i);
      start_i  <= 1'b0;
      action_i <= 2'($urandom);
      value_i  <= $urandom;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start_i  <= 1'b1;
    action_i <= act;
    value_i  <= val;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    track_word(act, val);
    if (act != ACT_UNUSED) words_sent++;
    if (act == ACT_COMPARE) compares_sent++;
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic shuffle_words(ref word_t q[$]);
    int j;
    int r;
    word_t t;
    for (j = q.size() - 1; j > 0; j--) begin
      r    = $urandom_range(0, j);
      t    = q[j];
      q[j] = q[r];
      q[r] = t;
    end
  endtask

  // two lists from one pool, b possibly altered or unrelated, loaded interleaved, then compared
  task automatic send_set_pair(input int len_a, input int len_b, input mix_e mix);
    word_t pool[$];
    word_t seq_a[$];
    word_t seq_b[$];
    int    n_pool;
    int    j;
    n_pool = (len_a < len_b) ? len_a : len_b;
    if (n_pool > 6) n_pool = 6;
    n_pool = (n_pool == 0) ? 1 : $urandom_range(1, n_pool);
    for (j = 0; j < n_pool; j++) pool.insert(pool.size(), pick_value());
    for (j = 0; j < len_a; j++) begin
      seq_a.insert(seq_a.size(),
                   (j < n_pool) ? pool[j] : pool[$urandom_range(0, n_pool - 1)]);
    end
    for (j = 0; j < len_b; j++) begin
      if (mix == MIX_UNRELATED) begin
        seq_b.insert(seq_b.size(), pick_value());
      end else begin
        seq_b.insert(seq_b.size(),
                     (j < n_pool) ? pool[j] : pool[$urandom_range(0, n_pool - 1)]);
      end
    end
    if (mix == MIX_ALTERED && len_b > 0) begin
      j        = $urandom_range(0, len_b - 1);
      seq_b[j] = seq_b[j] ^ (word_t'(1) << $urandom_range(0, DATA_W - 1));
    end
    shuffle_words(seq_a);
    shuffle_words(seq_b);
    while (seq_a.size() + seq_b.size() > 0) begin
      if ($urandom_range(0, 29) == 0) send_word(ACT_UNUSED, $urandom);
      if (seq_b.size() == 0 || (seq_a.size() != 0 && $urandom_range(0, 1) == 0))
        send_word(ACT_APPEND_A, seq_a.pop_front());
      else
        send_word(ACT_APPEND_B, seq_b.pop_front());
    end
    send_word(ACT_COMPARE, $urandom);
  endtask

  task automatic test_empty_lists();
    send_word(ACT_COMPARE, $urandom);
    send_word(ACT_APPEND_A, 32'h0000_0000);
    send_word(ACT_COMPARE, $urandom);
    send_word(ACT_APPEND_B, 32'h0000_0005);
    send_word(ACT_COMPARE, $urandom);
  endtask

  task automatic test_extremes();
    send_word(ACT_APPEND_A, 32'h8000_0000);
    send_word(ACT_APPEND_A, 32'h7fff_ffff);
    send_word(ACT_APPEND_A, 32'hffff_ffff);
    send_word(ACT_APPEND_A, 32'h0000_0000);
    send_word(ACT_APPEND_B, 32'h0000_0000);
    send_word(ACT_APPEND_B, 32'h7fff_ffff);
    send_word(ACT_APPEND_B, 32'h8000_0000);
    send_word(ACT_APPEND_B, 32'hffff_ffff);
    send_word(ACT_APPEND_B, 32'h8000_0000);
    send_word(ACT_COMPARE, 32'hffff_ffff);
    send_word(ACT_APPEND_A, 32'h8000_0000);
    send_word(ACT_APPEND_B, 32'h7fff_ffff);
    send_word(ACT_COMPARE, 32'h0000_0000);
  endtask

  task automatic test_unused_action();
    send_word(ACT_UNUSED, 32'hffff_ffff);
    send_word(ACT_APPEND_A, 32'h0000_0003);
    send_word(ACT_APPEND_B, 32'h0000_0003);
    send_word(ACT_UNUSED, 32'h0000_0004);
    send_word(ACT_COMPARE, $urandom);
    send_word(ACT_UNUSED, $urandom);
    send_word(ACT_COMPARE, $urandom);
  endtask

  task automatic test_overflow();
    word_t base;
    word_t rep;
    int    j;
    base = $urandom;
    // a overfull, b holds exactly the kept entries in reverse order
    for (j = 0; j < CAPACITY + 2; j++) send_word(ACT_APPEND_A, word_t'(base + j));
    for (j = 0; j < CAPACITY; j++) send_word(ACT_APPEND_B, word_t'(base + CAPACITY - 1 - j));
    send_word(ACT_COMPARE, $urandom);
    // b overfull, its dropped entry is missing from a
    base = $urandom;
    for (j = 0; j < CAPACITY; j++) send_word(ACT_APPEND_A, base ^ word_t'(j));
    for (j = 0; j < CAPACITY + 1; j++) send_word(ACT_APPEND_B, base ^ word_t'(j));
    send_word(ACT_COMPARE, $urandom);
    // a exactly full of one repeated value
    rep = pick_value();
    for (j = 0; j < CAPACITY; j++) send_word(ACT_APPEND_A, rep);
    send_word(ACT_APPEND_B, rep);
    send_word(ACT_COMPARE, $urandom);
    // overflow mark cleared by the previous compare
    send_word(ACT_COMPARE, $urandom);
  endtask

  task automatic test_drain_pause();
    send_word(ACT_APPEND_A, pick_value());
    send_word(ACT_APPEND_B, pick_value());
    send_word(ACT_COMPARE, $urandom);
    wait_for_verdicts();
    burst_mode = 1'b1;
    send_word(ACT_APPEND_B, 32'h0000_0001);
    send_word(ACT_APPEND_A, 32'h0000_0001);
    send_word(ACT_COMPARE, $urandom);
    send_word(ACT_COMPARE, $urandom);
    burst_mode = 1'b0;
  endtask

  task automatic test_random_sets();
    int   seq;
    int   len_a;
    int   len_b;
    int   roll;
    mix_e mix;
    seq = 0;
    while (words_sent < WORD_TARGET || compares_sent < MIN_COMPARES) begin
      seq++;
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) begin
        len_a = $urandom_range(CAPACITY - 3, CAPACITY + 3);
        len_b = $urandom_range(CAPACITY - 3, CAPACITY + 3);
      end else begin
        len_a = $urandom_range(0, 8);
        len_b = $urandom_range(0, 8);
      end
      roll = $urandom_range(0, 5);
      mix  = (roll < 4) ? MIX_EQUAL : (roll == 4) ? MIX_ALTERED : MIX_UNRELATED;
      send_set_pair(len_a, len_b, mix);
      if (seq % 12 == 0) wait_for_verdicts();
    end
    burst_mode = 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        note_failure("result word arrived with nothing pending");
      end else begin
        want = pending_verdicts.pop_front();
        if (same_o !== want.same || overflow_o !== want.overflow)
          note_failure($sformatf("mismatch: same exp %0b got %0b, overflow exp %0b got %0b",
                                 want.same, same_o, want.overflow, overflow_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("set_equality_checker verification failed");
      $finish;
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    action_i      = ACT_APPEND_A;
    value_i       = '0;
    fill_a        = 0;
    fill_b        = 0;
    lost_word     = 1'b0;
    words_sent    = 0;
    compares_sent = 0;
    fail_count    = 0;
    cycle_count   = 0;
    burst_mode    = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_lists();
    test_extremes();
    test_unused_action();
    test_overflow();
    test_drain_pause();
    test_random_sets();

    @(negedge clk_i);
    start_i <= 1'b0;
    wait_for_verdicts();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("set_equality_checker verification clean");
    end else begin
      $display("set_equality_checker verification failed");
    end
    $finish;
  end

endmodule
